// ===== hw/rtl/sgi_pkg.sv =====
// Shared types and helpers for the segment intersection pipeline.
// Used by every module in hw/rtl; depends on nothing else.
package sgi_pkg;

   localparam int CoordBits = 24;
   localparam int AbW       = CoordBits + 1;
   localparam int ProdW     = 2 * CoordBits + 1;
   localparam int CW        = 2 * CoordBits + 2;
   localparam int DetW      = 2 * CoordBits + 3;
   localparam int NumW      = 3 * CoordBits + 4;
   localparam int RemW      = DetW;

   localparam logic [CoordBits-1:0] CoordMax = {1'b0, {(CoordBits-1){1'b1}}};

   typedef logic signed [CoordBits-1:0] coord_type;

   typedef struct packed {
      coord_type p1x;
      coord_type p1y;
      coord_type p2x;
      coord_type p2y;
      coord_type q1x;
      coord_type q1y;
      coord_type q2x;
      coord_type q2y;
   } seg_type;

   typedef struct packed {
      logic                 valid;
      seg_type              seg;
      logic                 ok;
      logic                 neg_x;
      logic                 neg_y;
      logic                 ovf;
      logic [DetW-1:0]      dmag;
      logic [RemW-1:0]      rx;
      logic [CoordBits-1:0] lx;
      logic [CoordBits-1:0] qx;
      logic [RemW-1:0]      ry;
      logic [CoordBits-1:0] ly;
      logic [CoordBits-1:0] qy;
   } div_type;

   function automatic logic between(input logic signed [CoordBits:0] v,
                                    input coord_type p,
                                    input coord_type q);
      logic signed [CoordBits:0] pe;
      logic signed [CoordBits:0] qe;
      pe = p;
      qe = q;
      return ((pe < v) && (v < qe)) || ((qe < v) && (v < pe));
   endfunction

endpackage

// ===== hw/rtl/sgi_front.sv =====
// Front pipeline: line coefficients, determinant, numerators and divider setup.
// Uses sgi_pkg types; feeds the first divider cell.
module sgi_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  sgi_pkg::seg_type  seg_in,
   input  logic [31:0]       thr,
   output sgi_pkg::div_type  out
);

   // Stage 1
   logic v1_ff;
   sgi_pkg::seg_type s1_ff;
   logic signed [sgi_pkg::AbW-1:0] a1_ff, b1_ff, a2_ff, b2_ff;
   logic signed [sgi_pkg::AbW-1:0] a1_in, b1_in, a2_in, b2_in;

   // Stage 2
   logic v2_ff;
   sgi_pkg::seg_type s2_ff;
   logic signed [sgi_pkg::AbW-1:0] a1_2_ff, b1_2_ff, a2_2_ff, b2_2_ff;
   logic signed [sgi_pkg::ProdW-1:0] m1_ff, m2_ff, m3_ff, m4_ff;
   logic signed [sgi_pkg::CW-1:0] d0_ff, d1_ff;
   logic signed [sgi_pkg::ProdW-1:0] m1_in, m2_in, m3_in, m4_in;
   logic signed [sgi_pkg::CW-1:0] d0_in, d1_in;

   // Stage 3
   logic v3_ff;
   sgi_pkg::seg_type s3_ff;
   logic signed [sgi_pkg::AbW-1:0] a1_3_ff, b1_3_ff, a2_3_ff, b2_3_ff;
   logic signed [sgi_pkg::CW-1:0] c1_ff, c2_ff, c1_in, c2_in;
   logic signed [sgi_pkg::DetW-1:0] det_ff, det_in;

   // Stage 4
   logic v4_ff;
   sgi_pkg::seg_type s4_ff;
   logic signed [sgi_pkg::CW-1:0] ph_ff [4];
   logic signed [sgi_pkg::CW:0] pl_ff [4];
   logic signed [sgi_pkg::CW-1:0] ph_in [4];
   logic signed [sgi_pkg::CW:0] pl_in [4];
   logic signed [sgi_pkg::AbW-1:0] c1h, c2h;
   logic signed [sgi_pkg::AbW:0] c1l, c2l;
   logic [sgi_pkg::DetW-1:0] dmag4_ff, dmag4_in;
   logic ok4_ff, ok4_in, dneg4_ff;

   // Stage 5
   logic v5_ff;
   sgi_pkg::seg_type s5_ff;
   logic signed [sgi_pkg::NumW-1:0] f_ff [4];
   logic signed [sgi_pkg::NumW-1:0] f_in [4];
   logic signed [sgi_pkg::NumW-1:0] fh [4];
   logic signed [sgi_pkg::NumW-1:0] fl [4];
   logic [sgi_pkg::DetW-1:0] dmag5_ff;
   logic ok5_ff, dneg5_ff;

   // Stage 6
   logic v6_ff;
   sgi_pkg::seg_type s6_ff;
   logic signed [sgi_pkg::NumW-1:0] nx_ff, ny_ff, nx_in, ny_in;
   logic [sgi_pkg::DetW-1:0] dmag6_ff;
   logic ok6_ff, dneg6_ff;

   // Stage 7
   logic v7_ff;
   sgi_pkg::seg_type s7_ff;
   logic [sgi_pkg::NumW-1:0] mx_ff, my_ff, mx_in, my_in;
   logic negx7_ff, negy7_ff, negx7_in, negy7_in;
   logic [sgi_pkg::DetW-1:0] dmag7_ff;
   logic ok7_ff;

   // Stage 8
   sgi_pkg::div_type o_ff, o_in;
   logic [sgi_pkg::NumW-1:0] dsh;

   always_comb begin
      a1_in = sgi_pkg::AbW'(seg_in.p2y) - sgi_pkg::AbW'(seg_in.p1y);
      b1_in = sgi_pkg::AbW'(seg_in.p1x) - sgi_pkg::AbW'(seg_in.p2x);
      a2_in = sgi_pkg::AbW'(seg_in.q2y) - sgi_pkg::AbW'(seg_in.q1y);
      b2_in = sgi_pkg::AbW'(seg_in.q1x) - sgi_pkg::AbW'(seg_in.q2x);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= seg_in;
         a1_ff <= a1_in;
         b1_ff <= b1_in;
         a2_ff <= a2_in;
         b2_ff <= b2_in;
      end
   end

   always_comb begin
      m1_in = a1_ff * s1_ff.p1x;
      m2_in = b1_ff * s1_ff.p1y;
      m3_in = a2_ff * s1_ff.q1x;
      m4_in = b2_ff * s1_ff.q1y;
      d0_in = a1_ff * b2_ff;
      d1_in = a2_ff * b1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff   <= s1_ff;
         a1_2_ff <= a1_ff;
         b1_2_ff <= b1_ff;
         a2_2_ff <= a2_ff;
         b2_2_ff <= b2_ff;
         m1_ff   <= m1_in;
         m2_ff   <= m2_in;
         m3_ff   <= m3_in;
         m4_ff   <= m4_in;
         d0_ff   <= d0_in;
         d1_ff   <= d1_in;
      end
   end

   always_comb begin
      c1_in  = sgi_pkg::CW'(m1_ff) + sgi_pkg::CW'(m2_ff);
      c2_in  = sgi_pkg::CW'(m3_ff) + sgi_pkg::CW'(m4_ff);
      det_in = sgi_pkg::DetW'(d0_ff) - sgi_pkg::DetW'(d1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ff   <= s2_ff;
         a1_3_ff <= a1_2_ff;
         b1_3_ff <= b1_2_ff;
         a2_3_ff <= a2_2_ff;
         b2_3_ff <= b2_2_ff;
         c1_ff   <= c1_in;
         c2_ff   <= c2_in;
         det_ff  <= det_in;
      end
   end

   // Each wide product is split into a signed upper and an unsigned lower half of c.
   always_comb begin
      c1h = c1_ff[sgi_pkg::CW-1:sgi_pkg::AbW];
      c2h = c2_ff[sgi_pkg::CW-1:sgi_pkg::AbW];
      c1l = {1'b0, c1_ff[sgi_pkg::AbW-1:0]};
      c2l = {1'b0, c2_ff[sgi_pkg::AbW-1:0]};
      ph_in[0] = b2_3_ff * c1h;
      pl_in[0] = b2_3_ff * c1l;
      ph_in[1] = b1_3_ff * c2h;
      pl_in[1] = b1_3_ff * c2l;
      ph_in[2] = a1_3_ff * c2h;
      pl_in[2] = a1_3_ff * c2l;
      ph_in[3] = a2_3_ff * c1h;
      pl_in[3] = a2_3_ff * c1l;
      dmag4_in = det_ff[sgi_pkg::DetW-1] ? sgi_pkg::DetW'(-det_ff) : det_ff;
      ok4_in   = dmag4_in > sgi_pkg::DetW'(thr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_ff    <= s3_ff;
         ph_ff    <= ph_in;
         pl_ff    <= pl_in;
         dmag4_ff <= dmag4_in;
         ok4_ff   <= ok4_in;
         dneg4_ff <= det_ff[sgi_pkg::DetW-1];
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         fh[i]   = sgi_pkg::NumW'(ph_ff[i]);
         fl[i]   = sgi_pkg::NumW'(pl_ff[i]);
         f_in[i] = (fh[i] <<< sgi_pkg::AbW) + fl[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_ff    <= s4_ff;
         f_ff     <= f_in;
         dmag5_ff <= dmag4_ff;
         ok5_ff   <= ok4_ff;
         dneg5_ff <= dneg4_ff;
      end
   end

   always_comb begin
      nx_in = f_ff[0] - f_ff[1];
      ny_in = f_ff[2] - f_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_ff    <= s5_ff;
         nx_ff    <= nx_in;
         ny_ff    <= ny_in;
         dmag6_ff <= dmag5_ff;
         ok6_ff   <= ok5_ff;
         dneg6_ff <= dneg5_ff;
      end
   end

   always_comb begin
      mx_in    = nx_ff[sgi_pkg::NumW-1] ? sgi_pkg::NumW'(-nx_ff) : nx_ff;
      my_in    = ny_ff[sgi_pkg::NumW-1] ? sgi_pkg::NumW'(-ny_ff) : ny_ff;
      negx7_in = nx_ff[sgi_pkg::NumW-1] ^ dneg6_ff;
      negy7_in = ny_ff[sgi_pkg::NumW-1] ^ dneg6_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (en) begin
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_ff    <= s6_ff;
         mx_ff    <= mx_in;
         my_ff    <= my_in;
         negx7_ff <= negx7_in;
         negy7_ff <= negy7_in;
         dmag7_ff <= dmag6_ff;
         ok7_ff   <= ok6_ff;
      end
   end

   // A numerator at or above the divisor shifted by the quotient width lands outside any box.
   always_comb begin
      dsh          = {1'b0, dmag7_ff, {sgi_pkg::CoordBits{1'b0}}};
      o_in.valid   = v7_ff;
      o_in.seg     = s7_ff;
      o_in.ok      = ok7_ff;
      o_in.neg_x   = negx7_ff;
      o_in.neg_y   = negy7_ff;
      o_in.ovf     = (mx_ff >= dsh) || (my_ff >= dsh);
      o_in.dmag    = dmag7_ff;
      o_in.rx      = mx_ff[sgi_pkg::NumW-2:sgi_pkg::CoordBits];
      o_in.lx      = mx_ff[sgi_pkg::CoordBits-1:0];
      o_in.qx      = '0;
      o_in.ry      = my_ff[sgi_pkg::NumW-2:sgi_pkg::CoordBits];
      o_in.ly      = my_ff[sgi_pkg::CoordBits-1:0];
      o_in.qy      = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_ff.valid <= 1'b0;
      end else if (en) begin
         o_ff <= o_in;
      end
   end

   assign out = o_ff;

endmodule

// ===== hw/rtl/sgi_div_cell.sv =====
// One restoring-division cell: develops one quotient bit for x and one for y.
// Uses sgi_pkg::div_type; chained in the top level.
module sgi_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  sgi_pkg::div_type  d_in,
   output sgi_pkg::div_type  d_out
);

   sgi_pkg::div_type cell_ff, cell_in;
   logic [sgi_pkg::RemW:0] tx, ty, dv;
   logic gex, gey;

   always_comb begin
      dv  = {1'b0, d_in.dmag};
      tx  = {d_in.rx, d_in.lx[sgi_pkg::CoordBits-1]};
      ty  = {d_in.ry, d_in.ly[sgi_pkg::CoordBits-1]};
      gex = tx >= dv;
      gey = ty >= dv;
      cell_in    = d_in;
      cell_in.rx = gex ? sgi_pkg::RemW'(tx - dv) : tx[sgi_pkg::RemW-1:0];
      cell_in.ry = gey ? sgi_pkg::RemW'(ty - dv) : ty[sgi_pkg::RemW-1:0];
      cell_in.lx = {d_in.lx[sgi_pkg::CoordBits-2:0], 1'b0};
      cell_in.ly = {d_in.ly[sgi_pkg::CoordBits-2:0], 1'b0};
      cell_in.qx = {d_in.qx[sgi_pkg::CoordBits-2:0], gex};
      cell_in.qy = {d_in.qy[sgi_pkg::CoordBits-2:0], gey};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign d_out = cell_ff;

endmodule

// ===== hw/rtl/sgi_tail.sv =====
// Result stage: signs the quotients, runs the strict box tests and holds the output beat.
// Uses sgi_pkg types and the between helper.
module sgi_tail (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  sgi_pkg::div_type                 d_in,
   output logic                             out_valid,
   output logic                             out_hit,
   output logic [sgi_pkg::CoordBits-1:0]    out_x,
   output logic [sgi_pkg::CoordBits-1:0]    out_y
);

   logic signed [sgi_pkg::CoordBits:0] xv, yv;
   logic hit_in, valid_ff, hit_ff;
   logic [sgi_pkg::CoordBits-1:0] x_in, y_in, x_ff, y_ff;

   always_comb begin
      xv = d_in.neg_x ? -{1'b0, d_in.qx} : {1'b0, d_in.qx};
      yv = d_in.neg_y ? -{1'b0, d_in.qy} : {1'b0, d_in.qy};
      hit_in = d_in.ok && !d_in.ovf
             && sgi_pkg::between(xv, d_in.seg.p1x, d_in.seg.p2x)
             && sgi_pkg::between(yv, d_in.seg.p1y, d_in.seg.p2y)
             && sgi_pkg::between(xv, d_in.seg.q1x, d_in.seg.q2x)
             && sgi_pkg::between(yv, d_in.seg.q1y, d_in.seg.q2y);
      x_in = hit_in ? xv[sgi_pkg::CoordBits-1:0] : sgi_pkg::CoordMax;
      y_in = hit_in ? yv[sgi_pkg::CoordBits-1:0] : sgi_pkg::CoordMax;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= d_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= hit_in;
         x_ff   <= x_in;
         y_ff   <= y_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_hit   = hit_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;

endmodule

// ===== hw/rtl/segment_intersection.sv =====
// Top level of the 2D segment intersection block.
// Instantiates sgi_front, a chain of sgi_div_cell and sgi_tail; uses sgi_pkg.
//
// Usage: a request beat carries the four endpoints of two segments in signed
// Q15.8. A response beat carries hit and the crossing point, or hit low with
// both coordinates at the largest positive value.
// The block is a 33-stage pipeline: eight front stages form the coefficients,
// the determinant and the numerators, 24 divider cells each add one quotient
// bit to both coordinates, and a final stage runs the box tests and holds the
// response. One beat is taken every cycle unless a stalled response holds the pipeline.
// While a response waits under rsp_stall the whole pipeline holds and
// req_stall is high; everything else keeps moving.
// Reset empties the pipeline and sets det_threshold to 1. The threshold is
// written over the CSR port at byte address 0 and reads back at the same place.
module segment_intersection (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [23:0] req_first_start_x,
   input  logic [23:0] req_first_start_y,
   input  logic [23:0] req_first_end_x,
   input  logic [23:0] req_first_end_y,
   input  logic [23:0] req_second_start_x,
   input  logic [23:0] req_second_start_y,
   input  logic [23:0] req_second_end_x,
   input  logic [23:0] req_second_end_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic [23:0] rsp_cross_x,
   output logic [23:0] rsp_cross_y,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [31:0] thr_ff, thr_in;
   logic en;
   sgi_pkg::seg_type seg;
   sgi_pkg::div_type chain [sgi_pkg::CoordBits+1];

   always_comb begin
      thr_in = thr_ff;
      if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         thr_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 32'd1;
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign csr_prdata = csr_paddr[2] ? 32'd0 : thr_ff;
   assign csr_pready = 1'b1;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   always_comb begin
      seg.p1x = req_first_start_x;
      seg.p1y = req_first_start_y;
      seg.p2x = req_first_end_x;
      seg.p2y = req_first_end_y;
      seg.q1x = req_second_start_x;
      seg.q1y = req_second_start_y;
      seg.q2x = req_second_end_x;
      seg.q2y = req_second_end_y;
   end

   sgi_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .seg_in   (seg),
      .thr      (thr_ff),
      .out      (chain[0])
   );

   for (genvar i = 0; i < sgi_pkg::CoordBits; i++) begin : g_cell
      sgi_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .d_in  (chain[i]),
         .d_out (chain[i+1])
      );
   end

   sgi_tail u_tail (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .d_in      (chain[sgi_pkg::CoordBits]),
      .out_valid (rsp_valid),
      .out_hit   (rsp_hit),
      .out_x     (rsp_cross_x),
      .out_y     (rsp_cross_y)
   );

endmodule
